// ===== design/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the shader token comment scanner: scan
// phases, result codes, shader type codes and the result word layout.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int unsigned IDX_W   = 18;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned BYTES_W = 20;
    localparam int unsigned TOKEN_W = 32;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    typedef enum logic [1:0] {
        PH_VERSION = 2'd0,
        PH_SCAN    = 2'd1,
        PH_COMMENT = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    // result codes
    localparam logic [2:0] ST_FOUND       = 3'd0;
    localparam logic [2:0] ST_BAD_VERSION = 3'd1;
    localparam logic [2:0] ST_END_TOKEN   = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

    // shader kinds
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_VERTEX  = 2'd1;
    localparam logic [1:0] KIND_PIXEL   = 2'd2;

    // type codes in the high half of the version token
    localparam logic [15:0] TYPE_FX      = 16'h4658;
    localparam logic [15:0] TYPE_TX      = 16'h5458;
    localparam logic [15:0] TYPE_RSV_A   = 16'h7FFE;
    localparam logic [15:0] TYPE_RSV_B   = 16'h7FFF;
    localparam logic [15:0] TYPE_VERTEX  = 16'hFFFE;
    localparam logic [15:0] TYPE_PIXEL   = 16'hFFFF;

    // special tokens
    localparam logic [31:0] END_TOKEN    = 32'h0000_FFFF;
    localparam logic [15:0] COMMENT_CODE = 16'hFFFE;

    // configuration register indexes
    localparam logic CFG_STREAM_BYTES = 1'b0;
    localparam logic CFG_SEARCH_MAGIC = 1'b1;

    localparam logic [31:0] MAGIC_RESET = 32'h4354_4142;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       shader_kind;
        logic [7:0]       version_major;
        logic [7:0]       version_minor;
        logic [IDX_W-1:0] payload_word_offset;
        logic [IDX_W-1:0] payload_bytes;
    } result_t;

endpackage

// ===== design/shader_token_comment_scanner.sv =====
// ----------------------------------------------------------------------------
// shader_token_comment_scanner
// Scans a stream of shader bytecode words for a comment whose first word
// matches a configured magic, and reports its payload position and size.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid / in_stall, one bytecode word (token, last) each
//   output channel out_valid / out_stall, at most one result word per buffer
//   config channel cfg_valid / cfg_ready, cfg_index 0 = stream_bytes,
//     1 = search_magic; cfg_ready is always high, write only while idle
// One word is taken every cycle while in_stall is low. A word is held in the
// input register, then the step logic updates the scan state and, on a
// decision or on the last word, loads the result register that drives
// out_valid; while that register is stalled the word waits in the input register.
// The input register refills in the same cycle the held word moves on, so
// a held result only blocks the input while the receiver stalls it.
// After a decision the remaining words up to last are consumed silently;
// last always rearms the scan for a new version token.
// Reset clears the scan state, stream_bytes to zero and search_magic to
// the four characters CTAB.
// ----------------------------------------------------------------------------
module shader_token_comment_scanner (
    input  logic        clk,
    input  logic        rst_n,
    // bytecode words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] token,
    input  logic        last,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  shader_kind,
    output logic [7:0]  version_major,
    output logic [7:0]  version_minor,
    output logic [17:0] payload_word_offset,
    output logic [17:0] payload_bytes,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic                                in_valid_reg;
    logic [stc_pkg::TOKEN_W-1:0]         token_reg;
    logic                                last_reg;
    logic                                out_valid_reg;
    stc_pkg::result_t                    result_reg;
    logic [stc_pkg::BYTES_W-1:0]         stream_bytes_reg;
    logic [stc_pkg::TOKEN_W-1:0]         search_magic_reg;

    logic                                advance;
    logic                                load_in;
    logic                                emit;
    stc_pkg::result_t                    result;

    // held word moves on whenever the result register can take a word
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load_in)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            token_reg <= token;
            last_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_bytes_reg <= '0;
            search_magic_reg <= stc_pkg::MAGIC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                stc_pkg::CFG_STREAM_BYTES: stream_bytes_reg <= cfg_data[stc_pkg::BYTES_W-1:0];
                stc_pkg::CFG_SEARCH_MAGIC: search_magic_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    stc_scan_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .token        (token_reg),
        .last         (last_reg),
        .stream_bytes (stream_bytes_reg),
        .search_magic (search_magic_reg),
        .emit         (emit),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            result_reg <= result;
    end

    assign out_valid           = out_valid_reg;
    assign status              = result_reg.status;
    assign shader_kind         = result_reg.shader_kind;
    assign version_major       = result_reg.version_major;
    assign version_minor       = result_reg.version_minor;
    assign payload_word_offset = result_reg.payload_word_offset;
    assign payload_bytes       = result_reg.payload_bytes;

endmodule

// ===== design/stc_scan_core.sv =====
// ----------------------------------------------------------------------------
// stc_scan_core
// Scan state and one-word step logic: version check, end and comment token
// decode, room check, magic compare, skipping of comment bodies.
// ----------------------------------------------------------------------------
module stc_scan_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [stc_pkg::TOKEN_W-1:0]       token,
    input  logic                              last,
    input  logic [stc_pkg::BYTES_W-1:0]       stream_bytes,
    input  logic [stc_pkg::TOKEN_W-1:0]       search_magic,
    output logic                              emit,
    output stc_pkg::result_t                  result
);

    stc_pkg::phase_t                 phase_reg, phase_next;
    logic [stc_pkg::IDX_W-1:0]       word_index_reg, word_index_next;
    logic [stc_pkg::SIZE_W-1:0]      skip_left_reg, skip_left_next;
    logic [stc_pkg::SIZE_W-1:0]      pending_size_reg, pending_size_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [7:0]                      major_reg, major_next;
    logic [7:0]                      minor_reg, minor_next;

    logic [stc_pkg::IDX_W:0]         idx_plus1;
    logic                            readable;
    logic [stc_pkg::IDX_W:0]         room;
    logic [stc_pkg::SIZE_W-1:0]      size;
    logic [stc_pkg::SIZE_W-1:0]      skip_dec;
    logic                            was_done;
    logic                            decided;
    logic                            type_ok;
    logic [1:0]                      type_kind;

    assign idx_plus1 = {1'b0, word_index_reg} + {{stc_pkg::IDX_W{1'b0}}, 1'b1};
    // word i is readable when 4*(i+1) fits in the buffer
    assign readable  = {idx_plus1, 2'b00} <= {1'b0, stream_bytes};
    // words left after this one, valid only while readable
    assign room      = {1'b0, stream_bytes[stc_pkg::BYTES_W-1:2]} - idx_plus1;
    assign size      = token[31:16];
    assign skip_dec  = skip_left_reg - {{(stc_pkg::SIZE_W-1){1'b0}}, 1'b1};
    assign was_done  = (phase_reg == stc_pkg::PH_DONE);

    always_comb
    begin
        type_ok   = 1'b1;
        type_kind = stc_pkg::KIND_UNKNOWN;
        case (token[31:16])
            stc_pkg::TYPE_FX, stc_pkg::TYPE_TX,
            stc_pkg::TYPE_RSV_A, stc_pkg::TYPE_RSV_B: type_kind = stc_pkg::KIND_UNKNOWN;
            stc_pkg::TYPE_VERTEX:                     type_kind = stc_pkg::KIND_VERTEX;
            stc_pkg::TYPE_PIXEL:                      type_kind = stc_pkg::KIND_PIXEL;
            default:                                  type_ok   = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next          = phase_reg;
        word_index_next     = word_index_reg;
        skip_left_next      = skip_left_reg;
        pending_size_next   = pending_size_reg;
        kind_next           = kind_reg;
        major_next          = major_reg;
        minor_next          = minor_reg;
        decided             = 1'b0;
        result              = '0;
        result.status       = stc_pkg::ST_NOT_FOUND;

        case (phase_reg)
            stc_pkg::PH_VERSION:
            begin
                if (type_ok && (stream_bytes >= 20'd4))
                begin
                    kind_next  = type_kind;
                    major_next = token[15:8];
                    minor_next = token[7:0];
                    phase_next = stc_pkg::PH_SCAN;
                end
                else
                begin
                    kind_next     = stc_pkg::KIND_UNKNOWN;
                    major_next    = 8'd0;
                    minor_next    = 8'd0;
                    decided       = 1'b1;
                    result.status = stc_pkg::ST_BAD_VERSION;
                end
            end
            stc_pkg::PH_SCAN:
            begin
                if (!readable)
                begin
                    decided       = 1'b1;
                    result.status = stc_pkg::ST_NOT_FOUND;
                end
                else if (token == stc_pkg::END_TOKEN)
                begin
                    decided       = 1'b1;
                    result.status = stc_pkg::ST_END_TOKEN;
                end
                else if (token[15:0] == stc_pkg::COMMENT_CODE)
                begin
                    if ((size == '0) || ({3'b000, size} > room))
                    begin
                        decided       = 1'b1;
                        result.status = stc_pkg::ST_BAD_SIZE;
                    end
                    else
                    begin
                        pending_size_next = size;
                        skip_left_next    = size;
                        phase_next        = stc_pkg::PH_COMMENT;
                    end
                end
            end
            stc_pkg::PH_COMMENT:
            begin
                // first comment word carries the magic
                if ((skip_left_reg == pending_size_reg) && !readable)
                begin
                    decided       = 1'b1;
                    result.status = stc_pkg::ST_NOT_FOUND;
                end
                else if ((skip_left_reg == pending_size_reg) && (token == search_magic))
                begin
                    decided                    = 1'b1;
                    result.status              = stc_pkg::ST_FOUND;
                    result.payload_word_offset = idx_plus1[stc_pkg::IDX_W-1:0];
                    result.payload_bytes       = {skip_dec, 2'b00};
                end
                else
                begin
                    if (skip_left_reg != '0)
                        skip_left_next = skip_dec;
                    if ((skip_left_reg == '0) || (skip_dec == '0))
                        phase_next = stc_pkg::PH_SCAN;
                end
            end
            default:
            begin
            end
        endcase

        if (!was_done && (word_index_reg != stc_pkg::IDX_MAX))
            word_index_next = idx_plus1[stc_pkg::IDX_W-1:0];

        emit                 = decided || (last && !was_done);
        result.shader_kind   = kind_next;
        result.version_major = major_next;
        result.version_minor = minor_next;

        if (emit)
            phase_next = stc_pkg::PH_DONE;

        if (last)
        begin
            phase_next        = stc_pkg::PH_VERSION;
            word_index_next   = '0;
            skip_left_next    = '0;
            pending_size_next = '0;
            kind_next         = stc_pkg::KIND_UNKNOWN;
            major_next        = 8'd0;
            minor_next        = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= stc_pkg::PH_VERSION;
            word_index_reg   <= '0;
            skip_left_reg    <= '0;
            pending_size_reg <= '0;
            kind_reg         <= stc_pkg::KIND_UNKNOWN;
            major_reg        <= 8'd0;
            minor_reg        <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            word_index_reg   <= word_index_next;
            skip_left_reg    <= skip_left_next;
            pending_size_reg <= pending_size_next;
            kind_reg         <= kind_next;
            major_reg        <= major_next;
            minor_reg        <= minor_next;
        end
    end

endmodule

// ===== dv/shader_token_comment_scanner_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shader_token_comment_scanner_tb
// Feeds bytecode buffers into the comment scanner with random gaps and
// output stalls, predicts each scan result from its own copy of the scan
// state, and checks every result in order against that prediction.
// ----------------------------------------------------------------------------
module shader_token_comment_scanner_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [31:0] tok;
        logic        lst;
    } bc_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [31:0]               token = '0;
    logic                      last = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [2:0]                status;
    logic [1:0]                shader_kind;
    logic [7:0]                version_major;
    logic [7:0]                version_minor;
    logic [stc_pkg::IDX_W-1:0] payload_word_offset;
    logic [stc_pkg::IDX_W-1:0] payload_bytes;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_index = stc_pkg::CFG_STREAM_BYTES;
    logic [31:0]               cfg_data = '0;

    // scan state and register copies
    stc_pkg::phase_t           scan_phase = stc_pkg::PH_VERSION;
    logic [stc_pkg::IDX_W-1:0] scan_idx = '0;
    logic [15:0]               skip_cnt = '0;
    logic [15:0]               comment_size = '0;
    logic [1:0]                kind_q = '0;
    logic [7:0]                major_q = '0;
    logic [7:0]                minor_q = '0;
    logic [19:0]               buf_bytes = '0;
    logic [31:0]               magic_word = stc_pkg::MAGIC_RESET;

    bc_word_t                  pending_words[$];
    stc_pkg::result_t          expected_results[$];
    int                        queued_words = 0;
    int                        mismatches = 0;
    int                        cycle_count = 0;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    int                        hold_seq = 0;
    int                        hold_seen = 0;
    int                        hold_left = 0;
    bit                        word_accepted = 1'b0;
    bc_word_t                  next_word;
    stc_pkg::result_t          seen_result;
    stc_pkg::result_t          want_result;

    shader_token_comment_scanner DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .token               (token),
        .last                (last),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .shader_kind         (shader_kind),
        .version_major       (version_major),
        .version_minor       (version_minor),
        .payload_word_offset (payload_word_offset),
        .payload_bytes       (payload_bytes),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit readable(input logic [stc_pkg::IDX_W-1:0] idx);
        return (int'(idx) + 1) * 4 <= int'(buf_bytes);
    endfunction

    // advance the scan by one accepted word, queue the result it decides
    function automatic void scan_word(input logic [31:0] tok, input logic lst);
        logic             was_done;
        logic             decided;
        stc_pkg::result_t res;
        int               room;
        was_done = (scan_phase == stc_pkg::PH_DONE);
        decided = 1'b0;
        res = '0;
        res.status = stc_pkg::ST_NOT_FOUND;
        case (scan_phase)
            stc_pkg::PH_VERSION:
            begin
                if (buf_bytes < 20'd4)
                    decided = 1'b1;
                else
                    case (tok[31:16])
                        stc_pkg::TYPE_FX, stc_pkg::TYPE_TX,
                        stc_pkg::TYPE_RSV_A, stc_pkg::TYPE_RSV_B:
                            kind_q = stc_pkg::KIND_UNKNOWN;
                        stc_pkg::TYPE_VERTEX: kind_q = stc_pkg::KIND_VERTEX;
                        stc_pkg::TYPE_PIXEL:  kind_q = stc_pkg::KIND_PIXEL;
                        default:              decided = 1'b1;
                    endcase
                if (decided)
                begin
                    kind_q = '0;
                    major_q = '0;
                    minor_q = '0;
                    res.status = stc_pkg::ST_BAD_VERSION;
                end
                else
                begin
                    major_q = tok[15:8];
                    minor_q = tok[7:0];
                    scan_phase = stc_pkg::PH_SCAN;
                end
            end
            stc_pkg::PH_SCAN:
            begin
                if (!readable(scan_idx))
                    decided = 1'b1;
                else if (tok == stc_pkg::END_TOKEN)
                begin
                    decided = 1'b1;
                    res.status = stc_pkg::ST_END_TOKEN;
                end
                else if (tok[15:0] == stc_pkg::COMMENT_CODE)
                begin
                    room = (int'(buf_bytes) - int'(scan_idx) * 4 - 4) / 4;
                    if (tok[31:16] == 16'd0 || int'(tok[31:16]) > room)
                    begin
                        decided = 1'b1;
                        res.status = stc_pkg::ST_BAD_SIZE;
                    end
                    else
                    begin
                        comment_size = tok[31:16];
                        skip_cnt = tok[31:16];
                        scan_phase = stc_pkg::PH_COMMENT;
                    end
                end
            end
            stc_pkg::PH_COMMENT:
            begin
                if (skip_cnt == comment_size && !readable(scan_idx))
                    decided = 1'b1;
                else if (skip_cnt == comment_size && tok == magic_word)
                begin
                    decided = 1'b1;
                    res.status = stc_pkg::ST_FOUND;
                    res.payload_word_offset = scan_idx + 1'b1;
                    res.payload_bytes = 18'((int'(comment_size) - 1) * 4);
                end
                else
                begin
                    if (skip_cnt != 16'd0)
                        skip_cnt = skip_cnt - 1'b1;
                    if (skip_cnt == 16'd0)
                        scan_phase = stc_pkg::PH_SCAN;
                end
            end
            default:
                ;
        endcase

        if (!was_done && scan_idx != stc_pkg::IDX_MAX)
            scan_idx = scan_idx + 1'b1;

        if (decided || (lst && !was_done))
        begin
            res.shader_kind = kind_q;
            res.version_major = major_q;
            res.version_minor = minor_q;
            expected_results.push_back(res);
            scan_phase = stc_pkg::PH_DONE;
        end

        // last always rearms for a fresh version token
        if (lst)
        begin
            scan_phase = stc_pkg::PH_VERSION;
            scan_idx = '0;
            skip_cnt = '0;
            comment_size = '0;
            kind_q = '0;
            major_q = '0;
            minor_q = '0;
        end
    endfunction

    function automatic void flag_result(input string what, input stc_pkg::result_t seen,
                                        input stc_pkg::result_t want);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: got st=%0d kind=%0d ver=%0d.%0d off=%0d bytes=%0d,",
                      " want st=%0d kind=%0d ver=%0d.%0d off=%0d bytes=%0d"},
                     $realtime, what, seen.status, seen.shader_kind, seen.version_major,
                     seen.version_minor, seen.payload_word_offset, seen.payload_bytes,
                     want.status, want.shader_kind, want.version_major, want.version_minor,
                     want.payload_word_offset, want.payload_bytes);
    endfunction

    // input side: accept at the rising edge, present the next word at the falling edge
    always @(posedge clk)
    begin
        word_accepted = rst_n && in_valid && !in_stall;
        if (word_accepted)
            scan_word(token, last);
    end

    always @(negedge clk)
    begin
        if (!in_valid || word_accepted)
        begin
            if (rst_n && pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_word = pending_words.pop_front();
                in_valid <= 1'b1;
                token <= next_word.tok;
                last <= next_word.lst;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result.status = status;
            seen_result.shader_kind = shader_kind;
            seen_result.version_major = version_major;
            seen_result.version_minor = version_minor;
            seen_result.payload_word_offset = payload_word_offset;
            seen_result.payload_bytes = payload_bytes;
            if (expected_results.size() == 0)
                flag_result("unexpected result", seen_result, '0);
            else
            begin
                want_result = expected_results.pop_front();
                if (seen_result !== want_result)
                    flag_result("result mismatch", seen_result, want_result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_word(input logic [31:0] tok, input logic lst);
        pending_words.push_back({tok, lst});
        queued_words++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == stc_pkg::CFG_STREAM_BYTES)
            buf_bytes = data[19:0];
        else
            magic_word = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every word is taken and every result has come back
    task automatic settle();
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one buffer: version token, then plain words, comments and end tokens
    task automatic build_buffer(input int max_len);
        int          len;
        int          n;
        int          pick;
        logic [15:0] size;
        logic [31:0] ver;
        len = $urandom_range(1, max_len);
        ver = $urandom;
        if ($urandom_range(99) >= 10)
            case ($urandom_range(5))
                0: ver[31:16] = stc_pkg::TYPE_FX;
                1: ver[31:16] = stc_pkg::TYPE_TX;
                2: ver[31:16] = stc_pkg::TYPE_RSV_A;
                3: ver[31:16] = stc_pkg::TYPE_RSV_B;
                4: ver[31:16] = stc_pkg::TYPE_VERTEX;
                default: ver[31:16] = stc_pkg::TYPE_PIXEL;
            endcase
        push_word(ver, len == 1);
        n = 1;
        while (n < len)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // mostly sizes that fit, now and then any size
                size = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
                push_word({size, stc_pkg::COMMENT_CODE}, n + 1 == len);
                n++;
                if (n < len)
                begin
                    push_word(($urandom_range(2) != 0) ? magic_word : $urandom, n + 1 == len);
                    n++;
                end
            end
            else if (pick < 42)
            begin
                push_word(stc_pkg::END_TOKEN, n + 1 == len);
                n++;
            end
            else
            begin
                push_word($urandom, n + 1 == len);
                n++;
            end
        end
    endtask

    initial
    begin
        int          start_words;
        int          max_len;
        logic [31:0] bytes_cfg;
        logic [31:0] magic_cfg;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // buffer size still zero: even the version token is out of range
        push_word({stc_pkg::TYPE_VERTEX, 16'h0300}, 1'b1);
        settle();

        write_reg(stc_pkg::CFG_STREAM_BYTES, 32'd64);
        // unknown type, trailing word ignored
        push_word({16'h1234, 16'h0300}, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        // end token
        push_word({stc_pkg::TYPE_VERTEX, 16'hFF00}, 1'b0);
        push_word(stc_pkg::END_TOKEN, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        // magic found with the reset magic
        push_word({stc_pkg::TYPE_PIXEL, 16'h00FF}, 1'b0);
        push_word({16'd2, stc_pkg::COMMENT_CODE}, 1'b0);
        push_word(stc_pkg::MAGIC_RESET, 1'b0);
        push_word(32'hA5A5_5A5A, 1'b1);
        // zero comment size
        push_word({stc_pkg::TYPE_FX, 16'h0101}, 1'b0);
        push_word({16'd0, stc_pkg::COMMENT_CODE}, 1'b0);
        push_word(32'h0000_0001, 1'b1);
        // comment larger than the buffer, decided on the last word
        push_word({stc_pkg::TYPE_TX, 16'h0202}, 1'b0);
        push_word({16'hFFFF, stc_pkg::COMMENT_CODE}, 1'b1);
        // comment skipped, nothing found by last
        push_word({stc_pkg::TYPE_RSV_A, 16'h0303}, 1'b0);
        push_word({16'd1, stc_pkg::COMMENT_CODE}, 1'b0);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        // last on the version token itself
        push_word({stc_pkg::TYPE_RSV_B, 16'hFFFF}, 1'b1);
        settle();

        // scan walks past the end of the buffer
        write_reg(stc_pkg::CFG_STREAM_BYTES, 32'd8);
        push_word({stc_pkg::TYPE_VERTEX, 16'h0200}, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        settle();

        // buffer shrinks while a comment is open, magic now out of range
        write_reg(stc_pkg::CFG_STREAM_BYTES, 32'd64);
        write_reg(stc_pkg::CFG_SEARCH_MAGIC, 32'hDEAD_BEEF);
        push_word({stc_pkg::TYPE_PIXEL, 16'h0300}, 1'b0);
        push_word({16'd3, stc_pkg::COMMENT_CODE}, 1'b0);
        settle();
        write_reg(stc_pkg::CFG_STREAM_BYTES, 32'd8);
        push_word(32'hDEAD_BEEF, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            max_len = 16;
            case (p)
                0:
                begin
                    bytes_cfg = 32'hFFFF_FFFF;
                    magic_cfg = 32'h0000_0000;
                end
                1:
                begin
                    bytes_cfg = $urandom_range(7);
                    magic_cfg = 32'hFFFF_FFFF;
                    max_len = 3;
                end
                default:
                begin
                    bytes_cfg = $urandom_range(24, 120);
                    magic_cfg = ($urandom_range(1) != 0) ? stc_pkg::MAGIC_RESET : $urandom;
                end
            endcase
            write_reg(stc_pkg::CFG_STREAM_BYTES, bytes_cfg);
            write_reg(stc_pkg::CFG_SEARCH_MAGIC, magic_cfg);

            // no gaps on either side for one whole stretch
            idle_pct = (p == 2 || p == 3) ? 0 : 24;
            stall_pct = (p == 2) ? 0 : 24;
            if (p == 3)
            begin
                hold_seq++;
                max_len = 4;
            end

            start_words = queued_words;
            while (queued_words - start_words < ((p == 1) ? 40 : 85))
                build_buffer(max_len);
            settle();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
